// ----- hdl/sfb_pkg.sv -----
// Shared widths, types, register codes and reset values of the seam feather blender.
// Depends on nothing; every other file of the block imports it.
package sfb_pkg;

	localparam int PIX_W      = 8;
	localparam int COL_W      = 13;
	localparam int WIDTH_W    = 13;
	localparam int SEAM_W     = 12;
	localparam int SPAN_W     = 13;
	localparam int NUM_W      = 21;
	localparam int NLANES     = 3;
	localparam int DIV_STEPS  = PIX_W;
	localparam int PIPE_DEPTH = DIV_STEPS + 2;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 13;

	localparam int unsigned MAX_COLUMNS = 8192;

	typedef logic [PIX_W-1:0]      pix_t;
	typedef logic [COL_W-1:0]      col_t;
	typedef logic [WIDTH_W-1:0]    width_t;
	typedef logic [SEAM_W-1:0]     seam_t;
	typedef logic [SPAN_W-1:0]     span_t;
	typedef logic [NUM_W-1:0]      num_t;
	typedef logic [CFG_IDX_W-1:0]  cfg_idx_t;
	typedef logic [CFG_DATA_W-1:0] cfg_data_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_IMAGE_WIDTH = 1'd0,
		REG_SEAM_START  = 1'd1
	} cfg_reg_t;

	localparam width_t IMAGE_WIDTH_RST = 13'd640;
	localparam seam_t  SEAM_START_RST  = 12'd0;

	typedef struct packed {
		pix_t l;
		pix_t w;
	} lane_in_t;

	typedef struct packed {
		logic [PIPE_DEPTH-1:0]          en;
		span_t [PIPE_DEPTH-2:0]         span;
		span_t                          k;
	} pipe_ctrl_t;

endpackage

// ----- hdl/sfb_if.sv -----
// Valid/ready channel interfaces of the seam feather blender: pixel in, pixel out, config.
// Depends on sfb_pkg for the payload types.
interface sfb_pix_if import sfb_pkg::*; ();
	logic valid;
	logic ready;
	col_t column;
	pix_t left_ch0;
	pix_t left_ch1;
	pix_t left_ch2;
	pix_t warped_ch0;
	pix_t warped_ch1;
	pix_t warped_ch2;

	modport source (output valid, column, left_ch0, left_ch1, left_ch2,
		warped_ch0, warped_ch1, warped_ch2, input ready);
	modport sink (input valid, column, left_ch0, left_ch1, left_ch2,
		warped_ch0, warped_ch1, warped_ch2, output ready);
endinterface

interface sfb_out_if import sfb_pkg::*; ();
	logic valid;
	logic ready;
	pix_t out_ch0;
	pix_t out_ch1;
	pix_t out_ch2;

	modport source (output valid, out_ch0, out_ch1, out_ch2, input ready);
	modport sink (input valid, out_ch0, out_ch1, out_ch2, output ready);
endinterface

interface sfb_cfg_if import sfb_pkg::*; ();
	logic      valid;
	logic      ready;
	cfg_idx_t  index;
	cfg_data_t data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ----- hdl/seam_feather_blender.sv -----
//  channel  | role | handshake     | payload
//  pixel    | in   | valid, ready  | column, left_ch0..2, warped_ch0..2
//  blended  | out  | valid, ready  | out_ch0..2
//  cfg      | in   | valid, ready  | index, data (0 image_width, 1 seam_start)
//
// One word is taken every clock while the output is not stalled; each word passes one
// decode stage, one multiply-add stage and eight divide stages, one quotient bit each,
// before its result word is offered. A stalled output holds its word while bubbles further
// back still fill. Reset clears the occupancy and restores the register values; config
// writes are always taken. Depends on sfb_pkg, the sfb interfaces, sfb_decode,
// sfb_pipe_ctrl and sfb_lane.
module seam_feather_blender import sfb_pkg::*; (
	input logic            clk,
	input logic            arst_n,
	sfb_pix_if.sink        pixel,
	sfb_out_if.source      blended,
	sfb_cfg_if.sink        cfg
);

	width_t                width_q;
	seam_t                 seam_q;
	lane_in_t [NLANES-1:0] lanes;
	span_t                 k;
	span_t                 span;
	pipe_ctrl_t            ctrl;
	pix_t [NLANES-1:0]     res;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= IMAGE_WIDTH_RST;
			seam_q  <= SEAM_START_RST;
		end else if (cfg.valid) begin
			unique case (cfg_reg_t'(cfg.index))
				REG_IMAGE_WIDTH: width_q <= width_t'(cfg.data);
				REG_SEAM_START:  seam_q  <= cfg.data[SEAM_W-1:0];
				default: ;
			endcase
		end
	end

	sfb_decode u_decode (
		.column      (pixel.column),
		.left        ({pixel.left_ch2, pixel.left_ch1, pixel.left_ch0}),
		.warped      ({pixel.warped_ch2, pixel.warped_ch1, pixel.warped_ch0}),
		.image_width (width_q),
		.seam_start  (seam_q),
		.lanes       (lanes),
		.k           (k),
		.span        (span)
	);

	sfb_pipe_ctrl u_pipe_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (pixel.valid),
		.out_ready (blended.ready),
		.span      (span),
		.k         (k),
		.in_ready  (pixel.ready),
		.out_valid (blended.valid),
		.ctrl      (ctrl)
	);

	for (genvar i = 0; i < NLANES; i++) begin : g_lane
		sfb_lane u_lane (
			.clk     (clk),
			.lane_in (lanes[i]),
			.ctrl    (ctrl),
			.result  (res[i])
		);
	end

	assign blended.out_ch0 = res[0];
	assign blended.out_ch1 = res[1];
	assign blended.out_ch2 = res[2];

endmodule

// ----- hdl/sfb_decode.sv -----
// Classifies a pixel word against the seam and width registers and forms blend weights.
// Pass-through cases become a blend with unit span and zero weight. Depends on sfb_pkg.
module sfb_decode import sfb_pkg::*; (
	input  col_t                    column,
	input  pix_t [NLANES-1:0]       left,
	input  pix_t [NLANES-1:0]       warped,
	input  width_t                  image_width,
	input  seam_t                   seam_start,
	output lane_in_t [NLANES-1:0]   lanes,
	output span_t                   k,
	output span_t                   span
);

	logic beyond;
	logic below;
	logic black;
	logic blend;

	always_comb begin
		beyond = (column >= image_width) || (32'(column) >= MAX_COLUMNS);
		below  = column < col_t'(seam_start);
		black  = (warped == '0);
		blend  = !beyond && !below && !black;
		k      = blend ? span_t'(column - col_t'(seam_start)) : '0;
		span   = blend ? span_t'(image_width - width_t'(seam_start)) : span_t'(1);
		for (int i = 0; i < NLANES; i++) begin
			lanes[i].l = beyond ? warped[i] : left[i];
			lanes[i].w = warped[i];
		end
	end

endmodule

// ----- hdl/sfb_pipe_ctrl.sv -----
// Occupancy, stall chain and shared span/weight registers of the blend pipeline.
// Each stage moves when it is empty or the stage after it moves. Depends on sfb_pkg.
module sfb_pipe_ctrl import sfb_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic       out_ready,
	input  span_t      span,
	input  span_t      k,
	output logic       in_ready,
	output logic       out_valid,
	output pipe_ctrl_t ctrl
);

	logic [PIPE_DEPTH-1:0]  valid_q;
	logic [PIPE_DEPTH-1:0]  en;
	span_t [PIPE_DEPTH-2:0] span_q;
	span_t                  k_s1;

	always_comb begin
		en[PIPE_DEPTH-1] = !valid_q[PIPE_DEPTH-1] || out_ready;
		for (int j = PIPE_DEPTH - 2; j >= 0; j--) begin
			en[j] = !valid_q[j] || en[j+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else begin
			if (en[0]) begin
				valid_q[0] <= in_valid;
			end
			for (int j = 1; j < PIPE_DEPTH; j++) begin
				if (en[j]) begin
					valid_q[j] <= valid_q[j-1];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en[0]) begin
			span_q[0] <= span;
			k_s1      <= k;
		end
		for (int j = 1; j < PIPE_DEPTH - 1; j++) begin
			if (en[j]) begin
				span_q[j] <= span_q[j-1];
			end
		end
	end

	assign in_ready  = en[0];
	assign out_valid = valid_q[PIPE_DEPTH-1];
	assign ctrl.en   = en;
	assign ctrl.span = span_q;
	assign ctrl.k    = k_s1;

endmodule

// ----- hdl/sfb_lane.sv -----
// One colour channel: weighted sum, then a restoring divide by the span, one quotient
// bit per stage. Stage timing comes from sfb_pipe_ctrl. Depends on sfb_pkg.
module sfb_lane import sfb_pkg::*; (
	input  logic       clk,
	input  lane_in_t   lane_in,
	input  pipe_ctrl_t ctrl,
	output pix_t       result
);

	pix_t l_s1;
	pix_t w_s1;
	num_t sum;
	num_t rem_q [1:PIPE_DEPTH-2];
	num_t rem_d [2:PIPE_DEPTH-2];
	pix_t quo_q [2:PIPE_DEPTH-1];
	pix_t quo_d [2:PIPE_DEPTH-1];

	assign sum = num_t'(l_s1) * num_t'(ctrl.span[0] - ctrl.k) + num_t'(w_s1) * num_t'(ctrl.k);

	for (genvar j = 2; j < PIPE_DEPTH; j++) begin : g_step
		localparam int BIT = PIPE_DEPTH - 1 - j;
		num_t divisor;
		logic fits;
		pix_t quo_prev;

		assign divisor = num_t'(ctrl.span[j-1]) << BIT;
		assign fits    = rem_q[j-1] >= divisor;
		if (j == 2) begin : g_first
			assign quo_prev = '0;
		end else begin : g_next
			assign quo_prev = quo_q[j-1];
		end
		assign quo_d[j] = {quo_prev[PIX_W-2:0], fits};
		if (j < PIPE_DEPTH - 1) begin : g_rem
			assign rem_d[j] = fits ? rem_q[j-1] - divisor : rem_q[j-1];
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.en[0]) begin
			l_s1 <= lane_in.l;
			w_s1 <= lane_in.w;
		end
		if (ctrl.en[1]) begin
			rem_q[1] <= sum;
		end
		for (int j = 2; j < PIPE_DEPTH; j++) begin
			if (ctrl.en[j]) begin
				quo_q[j] <= quo_d[j];
			end
		end
		for (int j = 2; j < PIPE_DEPTH - 1; j++) begin
			if (ctrl.en[j]) begin
				rem_q[j] <= rem_d[j];
			end
		end
	end

	assign result = quo_q[PIPE_DEPTH-1];

endmodule

// ----- hdl/sfb_checker.sv -----
// Port-level checks of the seam feather blender: output handshake, occupancy and latency.
// Depends on sfb_pkg and the sfb interfaces; bound to the top level at the end of the file.
module sfb_checker import sfb_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	sfb_pix_if.sink   pixel,
	sfb_out_if.source blended
);

	localparam int CNT_W = $clog2(PIPE_DEPTH + 2);

	logic             in_acc;
	logic             out_acc;
	logic [CNT_W-1:0] inflight_q;
	logic [CNT_W-1:0] ready_run_q;

	assign in_acc  = pixel.valid && pixel.ready;
	assign out_acc = blended.valid && blended.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inflight_q  <= '0;
			ready_run_q <= '0;
		end else begin
			inflight_q <= inflight_q + CNT_W'(in_acc) - CNT_W'(out_acc);
			if (!blended.ready) begin
				ready_run_q <= '0;
			end else if (ready_run_q < CNT_W'(PIPE_DEPTH)) begin
				ready_run_q <= ready_run_q + CNT_W'(1);
			end
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		blended.valid && !blended.ready |=> blended.valid)
		else $error("result word dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		blended.valid && !blended.ready |=>
			$stable(blended.out_ch0) && $stable(blended.out_ch1) && $stable(blended.out_ch2))
		else $error("stalled result word changed");

	a_no_invented: assert property (@(posedge clk) disable iff (!arst_n)
		blended.valid |-> inflight_q != '0)
		else $error("result word shown with no pixel word in flight");

	a_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		inflight_q <= CNT_W'(PIPE_DEPTH))
		else $error("more pixel words in flight than pipeline stages");

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		$past(in_acc, PIPE_DEPTH) && ready_run_q >= CNT_W'(PIPE_DEPTH) |-> blended.valid)
		else $error("result word late with the output never stalled");

endmodule

bind seam_feather_blender sfb_checker u_sfb_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.pixel   (pixel),
	.blended (blended)
);
